/* hdl/ctkd_pkg.sv */
`default_nettype none
package ctkd_pkg;

   localparam int SAMPLE_W = 16;
   localparam int LOCK_W = 2;
   localparam int RSP_DATA_W = 40;

   localparam logic OP_CAL = 1'b0;
   localparam logic OP_SCAN = 1'b1;
   localparam logic KIND_CAL = 1'b0;
   localparam logic KIND_SCAN = 1'b1;

   typedef struct packed {
      logic capture;
      logic cal_write;
      logic scan_exec;
      logic sort_en;
      logic sort_phase;
      logic sum_clear;
      logic sum_add;
      logic div_start;
      logic base_load;
      logic thr_load;
      logic cal_out;
   } cmd_type;

   typedef struct packed {
      logic op;
      logic cal_last;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

/* hdl/ctkd_div.sv */
`default_nettype none
module ctkd_div #(
   parameter int DW = 19,
   parameter int DIVISOR = 3
) (
   input  wire logic          clock,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   output logic      [DW-1:0] quotient
);

   // floor(x / DIVISOR) as (x * RECIP) >> SHIFT, exact for every DW-bit x
   localparam int LOG_D = $clog2(DIVISOR);
   localparam int SHIFT = DW + LOG_D;
   localparam int RW = DW + 1;
   localparam logic [63:0] DIV64 = 64'(DIVISOR);
   localparam logic [RW-1:0] RECIP = RW'(((64'd1 << SHIFT) + DIV64 - 64'd1) / DIV64);

   logic [DW+RW-1:0] prod;
   logic [DW-1:0] q_ff, q_in;

   always_comb begin
      prod = (DW + RW)'(dividend) * (DW + RW)'(RECIP);
      q_in = q_ff;
      if (start) begin
         q_in = DW'(prod >> SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign quotient = q_ff;

endmodule
`default_nettype wire

/* hdl/ctkd_ctrl.sv */
`default_nettype none
module ctkd_ctrl #(
   parameter int CAL_N = 10,
   parameter int CNT_W = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire ctkd_pkg::status_type status,
   output ctkd_pkg::cmd_type         cmd,
   output logic [CNT_W-1:0]          step
);

   localparam int KEEP = CAL_N - 4;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_EXEC = 9'b000000010,
      ST_SORT = 9'b000000100,
      ST_SUM  = 9'b000001000,
      ST_DIVA = 9'b000010000,
      ST_BASE = 9'b000100000,
      ST_DIVB = 9'b001000000,
      ST_THR  = 9'b010000000,
      ST_OUT  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.op == ctkd_pkg::OP_CAL) begin
               cmd.cal_write = 1'b1;
               cnt_in = '0;
               state_in = status.cal_last ? ST_SORT : ST_IDLE;
            end else if (status.out_free) begin
               cmd.scan_exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SORT: begin
            cmd.sort_en = 1'b1;
            cmd.sort_phase = cnt_ff[0];
            if (cnt_ff == CNT_W'(CAL_N - 1)) begin
               cmd.sum_clear = 1'b1;
               cnt_in = '0;
               state_in = ST_SUM;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SUM: begin
            cmd.sum_add = 1'b1;
            if (cnt_ff == CNT_W'(KEEP - 1)) begin
               cnt_in = '0;
               state_in = ST_DIVA;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIVA: begin
            cmd.div_start = 1'b1;
            state_in = ST_BASE;
         end
         ST_BASE: begin
            cmd.base_load = 1'b1;
            state_in = ST_DIVB;
         end
         ST_DIVB: begin
            cmd.div_start = 1'b1;
            state_in = ST_THR;
         end
         ST_THR: begin
            cmd.thr_load = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.cal_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

   assign step = cnt_ff;

endmodule
`default_nettype wire

/* hdl/ctkd_dp.sv */
`default_nettype none
module ctkd_dp #(
   parameter int CAL_N = 10,
   parameter int LOCK_N = 3,
   parameter int CNT_W = 4
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire ctkd_pkg::cmd_type                    cmd,
   input  wire logic [CNT_W-1:0]                     step,
   output ctkd_pkg::status_type                      status,
   input  wire logic                                 req_tuser,
   input  wire logic [ctkd_pkg::SAMPLE_W-1:0]        req_tdata,
   input  wire logic                                 csr_write,
   input  wire logic                                 csr_data,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic                                      rsp_tuser,
   output logic      [ctkd_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int SW = ctkd_pkg::SAMPLE_W;
   localparam int KEEP = CAL_N - 4;
   localparam int SUM_W = SW + $clog2(KEEP);
   localparam int IDX_W = $clog2(CAL_N);
   localparam int THR_DIV = 3;
   localparam logic [2:0] GRP_SHORT = 3'd3;
   localparam logic [2:0] GRP_LONG = 3'd6;
   localparam logic [2:0] QUOTA_SHORT = 3'd2;
   localparam logic [2:0] QUOTA_LONG = 3'd4;
   localparam logic [2:0] CNT_MAX = 3'd7;
   localparam int PAD_W = ctkd_pkg::RSP_DATA_W - 2 * SW - 2;

   logic [SW-1:0] store_ff [CAL_N];
   logic [IDX_W-1:0] cal_cnt_ff, cal_cnt_in;
   logic [IDX_W-1:0] sum_idx;
   logic [SUM_W-1:0] sum_ff, sum_in;

   logic op_ff;
   logic [SW-1:0] samp_ff;
   logic mode_ff;
   logic [SW-1:0] base_ff, base_in;
   logic [SW:0] thr_ff, thr_in;
   logic [SW-1:0] peak_ff, peak_in;
   logic [2:0] ovr_ff, ovr_in;
   logic [2:0] sig_ff, sig_in;
   logic [ctkd_pkg::LOCK_W-1:0] lock_ff, lock_in;

   logic out_valid_ff, out_valid_in;
   logic out_kind_ff, out_press_ff, out_err_ff;
   logic [SW-1:0] out_peak_ff, out_base_ff;

   logic [SUM_W-1:0] sum_quot;
   logic [SW+1:0] thr_quot;

   logic [SW+2:0] b5;
   logic [SW:0] b54;
   logic [SW+3:0] b10;
   logic over;
   logic [2:0] ovr_nx, sig_nx, size, quota;
   logic [SW-1:0] peak_nx, grp_peak;
   logic grp_end, hit, press;
   logic [ctkd_pkg::LOCK_W-1:0] lock_base, lock_nx;

   // trimmed sum / KEEP gives the baseline, baseline*4 / 3 the press threshold
   ctkd_div #(.DW(SUM_W), .DIVISOR(KEEP)) u_div_sum (
      .clock    (clock),
      .start    (cmd.div_start),
      .dividend (sum_ff),
      .quotient (sum_quot)
   );

   ctkd_div #(.DW(SW + 2), .DIVISOR(THR_DIV)) u_div_thr (
      .clock    (clock),
      .start    (cmd.div_start),
      .dividend ({base_ff, 2'b00}),
      .quotient (thr_quot)
   );

   // threshold and group logic
   always_comb begin
      b5 = {1'b0, base_ff, 2'b00} + (SW + 3)'(base_ff);
      b54 = b5[SW+2:2];
      b10 = (SW + 4)'({base_ff, 3'b000}) + (SW + 4)'({base_ff, 1'b0});
      over = {1'b0, samp_ff} > b54;
      ovr_nx = (over && ovr_ff != CNT_MAX) ? ovr_ff + 3'd1 : ovr_ff;
      peak_nx = (samp_ff > peak_ff) ? samp_ff : peak_ff;
      sig_nx = (sig_ff != CNT_MAX) ? sig_ff + 3'd1 : sig_ff;
      size = mode_ff ? GRP_LONG : GRP_SHORT;
      quota = mode_ff ? QUOTA_LONG : QUOTA_SHORT;
      grp_end = sig_nx >= size;
      grp_peak = (ovr_nx >= quota) ? peak_nx : '0;
      hit = ({1'b0, grp_peak} > thr_ff) && ((SW + 4)'(grp_peak) < b10);
      lock_base = mode_ff ? '0 : lock_ff;
      press = hit && (lock_base == '0);
      if (hit) begin
         lock_nx = ctkd_pkg::LOCK_W'(LOCK_N - 1);
      end else if (lock_base != '0) begin
         lock_nx = lock_base - 1'b1;
      end else begin
         lock_nx = '0;
      end
   end

   always_comb begin
      cal_cnt_in = cal_cnt_ff;
      base_in = base_ff;
      thr_in = thr_ff;
      peak_in = peak_ff;
      ovr_in = ovr_ff;
      sig_in = sig_ff;
      lock_in = lock_ff;
      sum_in = sum_ff;
      sum_idx = step[IDX_W-1:0] + IDX_W'(2);
      if (cmd.cal_write) begin
         cal_cnt_in = status.cal_last ? '0 : cal_cnt_ff + 1'b1;
      end
      if (cmd.sum_clear) begin
         sum_in = '0;
      end else if (cmd.sum_add) begin
         sum_in = sum_ff + SUM_W'(store_ff[sum_idx]);
      end
      if (cmd.base_load) begin
         base_in = sum_quot[SW-1:0];
      end
      if (cmd.thr_load) begin
         thr_in = thr_quot[SW:0];
      end
      if (cmd.scan_exec) begin
         if (grp_end) begin
            peak_in = '0;
            ovr_in = '0;
            sig_in = '0;
            lock_in = lock_nx;
         end else begin
            peak_in = peak_nx;
            ovr_in = ovr_nx;
            sig_in = sig_nx;
         end
      end
      out_valid_in = out_valid_ff;
      if (cmd.cal_out || (cmd.scan_exec && grp_end)) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_cnt_ff <= '0;
         base_ff <= '0;
         thr_ff <= '0;
         peak_ff <= '0;
         ovr_ff <= '0;
         sig_ff <= '0;
         lock_ff <= '0;
         mode_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cal_cnt_ff <= cal_cnt_in;
         base_ff <= base_in;
         thr_ff <= thr_in;
         peak_ff <= peak_in;
         ovr_ff <= ovr_in;
         sig_ff <= sig_in;
         lock_ff <= lock_in;
         out_valid_ff <= out_valid_in;
         if (csr_write) begin
            mode_ff <= csr_data;
         end
      end
   end

   // calibration store: indexed write, odd-even transposition sort in place
   always_ff @(posedge clock) begin
      if (cmd.cal_write) begin
         store_ff[cal_cnt_ff] <= samp_ff;
      end else if (cmd.sort_en) begin
         for (int i = 0; i + 1 < CAL_N; i++) begin
            if (i[0] == cmd.sort_phase && store_ff[i] > store_ff[i+1]) begin
               store_ff[i] <= store_ff[i+1];
               store_ff[i+1] <= store_ff[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      if (cmd.capture) begin
         op_ff <= req_tuser;
         samp_ff <= req_tdata;
      end
      if (cmd.cal_out) begin
         out_kind_ff <= ctkd_pkg::KIND_CAL;
         out_press_ff <= 1'b0;
         out_peak_ff <= '0;
         out_base_ff <= base_ff;
         out_err_ff <= base_ff[SW-1];
      end else if (cmd.scan_exec && grp_end) begin
         out_kind_ff <= ctkd_pkg::KIND_SCAN;
         out_press_ff <= press;
         out_peak_ff <= grp_peak;
         out_base_ff <= base_ff;
         out_err_ff <= base_ff[SW-1];
      end
   end

   assign status.op = op_ff;
   assign status.cal_last = (cal_cnt_ff == IDX_W'(CAL_N - 1));
   assign status.out_free = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser = out_kind_ff;
   assign rsp_tdata = {{PAD_W{1'b0}}, out_err_ff, out_base_ff, out_peak_ff, out_press_ff};

endmodule
`default_nettype wire

/* hdl/capacitive_touch_key_detector_top.sv */
// Scan item: accepted in IDLE, executed in EXEC, where a group's last sample
// loads its result; a held result stalls the next scan. Calibration item that
// completes a round: CAL_N sort phases, CAL_N-4 sum additions and two
// registered reciprocal-multiply divisions, then the result. No new item is
// accepted until the block is back in IDLE after the last one.
// Synchronous reset clears the controller, counters, baseline, thresholds,
// mode and the output valid; the calibration store is not cleared.
`default_nettype none
module capacitive_touch_key_detector_top #(
   parameter int CALIBRATION_SAMPLES = 10,
   parameter int LOCKOUT_GROUPS = 3
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic                                req_tuser,  // op
   input  wire logic [ctkd_pkg::SAMPLE_W-1:0]       req_tdata,  // charge_time
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic                                     rsp_tuser,  // kind
   // pressed, group_peak, baseline_value, calibration_error, zero pad
   output logic      [ctkd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic                                csr_data    // continuous_mode
);

   localparam int CNT_W = $clog2(CALIBRATION_SAMPLES);

   ctkd_pkg::cmd_type cmd;
   ctkd_pkg::status_type status;
   logic [CNT_W-1:0] step;

   assign csr_ready = 1'b1;

   ctkd_ctrl #(
      .CAL_N (CALIBRATION_SAMPLES),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd),
      .step       (step)
   );

   ctkd_dp #(
      .CAL_N  (CALIBRATION_SAMPLES),
      .LOCK_N (LOCKOUT_GROUPS),
      .CNT_W  (CNT_W)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .step       (step),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_write  (csr_valid && csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_exec || cmd.cal_out) |-> status.out_free)
      else $error("result loaded over a pending item");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> !req_tready)
      else $error("input ready right after acceptance");

   a_cal_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ctkd_pkg::KIND_CAL) |->
         (rsp_tdata[16:0] == 17'd0))
      else $error("calibration item carries a peak or press");

   a_err_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[33] == rsp_tdata[32]))
      else $error("error flag disagrees with baseline");

endmodule
`default_nettype wire

/* sim/touch_key_checker.sv */
module touch_key_checker #(
   parameter int CALIBRATION_SAMPLES = 10,
   parameter int LOCKOUT_GROUPS = 3
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   input  wire logic                               req_tready,
   input  wire logic                               req_tuser,
   input  wire logic [ctkd_pkg::SAMPLE_W-1:0]      req_tdata,
   input  wire logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic                               rsp_tuser,
   input  wire logic [ctkd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  wire logic                               csr_valid,
   input  wire logic                               csr_ready,
   input  wire logic                               csr_data,
   output int                                      errors,
   output int                                      pending
);

   typedef struct packed {
      logic        kind;
      logic        pressed;
      logic [15:0] peak;
      logic [15:0] base;
      logic        cal_err;
   } touch_verdict_type;

   touch_verdict_type verdicts_due[$];

   logic [15:0] cal_store [CALIBRATION_SAMPLES];
   int unsigned cal_count;
   logic [15:0] baseline;
   int unsigned run_peak;
   int unsigned over_cnt;
   int unsigned grp_cnt;
   int unsigned lock_cnt;
   logic        cont;

   // sorted store, two lowest and two highest dropped, rest averaged
   function automatic logic [15:0] trimmed_mean();
      logic [15:0] ranked [CALIBRATION_SAMPLES];
      logic [15:0] t;
      int unsigned sum;
      int unsigned avg;
      int i;
      int j;
      sum = 0;
      for (i = 0; i < CALIBRATION_SAMPLES; i++) ranked[i] = cal_store[i];
      for (i = 0; i + 1 < CALIBRATION_SAMPLES; i++) begin
         for (j = i + 1; j < CALIBRATION_SAMPLES; j++) begin
            if (ranked[i] > ranked[j]) begin
               t = ranked[i];
               ranked[i] = ranked[j];
               ranked[j] = t;
            end
         end
      end
      for (i = 2; i + 2 < CALIBRATION_SAMPLES; i++) sum += 32'(ranked[i]);
      avg = sum / (CALIBRATION_SAMPLES - 4);
      return avg[15:0];
   endfunction

   task automatic predict_item(input logic op, input logic [15:0] v);
      int unsigned size;
      int unsigned quota;
      int unsigned peak;
      int unsigned base32;
      logic        pressed;
      touch_verdict_type due;
      base32 = 32'(baseline);
      if (op == ctkd_pkg::OP_CAL) begin
         if (cal_count < CALIBRATION_SAMPLES) cal_store[cal_count] = v;
         cal_count++;
         if (cal_count >= CALIBRATION_SAMPLES) begin
            cal_count = 0;
            baseline = trimmed_mean();
            due.kind = ctkd_pkg::KIND_CAL;
            due.pressed = 1'b0;
            due.peak = '0;
            due.base = baseline;
            due.cal_err = baseline[15];
            verdicts_due.push_back(due);
         end
      end else begin
         size = cont ? 6 : 3;
         quota = size * 2 / 3;
         if (32'(v) > base32 * 5 / 4 && over_cnt < 7) over_cnt++;
         if (32'(v) > run_peak) run_peak = 32'(v);
         if (grp_cnt < 7) grp_cnt++;
         if (grp_cnt >= size) begin
            peak = (over_cnt >= quota) ? run_peak : 0;
            run_peak = 0;
            over_cnt = 0;
            grp_cnt = 0;
            if (cont) lock_cnt = 0;
            pressed = 1'b0;
            if (peak > base32 * 4 / 3 && peak < base32 * 10) begin
               pressed = (lock_cnt == 0);
               lock_cnt = LOCKOUT_GROUPS;
            end
            if (lock_cnt != 0) lock_cnt--;
            lock_cnt &= 3;
            due.kind = ctkd_pkg::KIND_SCAN;
            due.pressed = pressed;
            due.peak = peak[15:0];
            due.base = baseline;
            due.cal_err = baseline[15];
            verdicts_due.push_back(due);
         end
      end
   endtask

   always @(posedge clock) begin : watch
      touch_verdict_type got;
      touch_verdict_type want;
      if (reset) begin
         cal_count = 0;
         baseline = '0;
         run_peak = 0;
         over_cnt = 0;
         grp_cnt = 0;
         lock_cnt = 0;
         cont = 1'b0;
         verdicts_due.delete();
         pending = 0;
         errors = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser;
            got.pressed = rsp_tdata[0];
            got.peak = rsp_tdata[16:1];
            got.base = rsp_tdata[32:17];
            got.cal_err = rsp_tdata[33];
            if (verdicts_due.size() == 0) begin
               if (errors < 10)
                  $display("%0t: unexpected result kind=%0b pressed=%0b peak=%0d base=%0d err=%0b",
                           $realtime, got.kind, got.pressed, got.peak, got.base, got.cal_err);
               errors++;
            end else begin
               want = verdicts_due.pop_front();
               if (got !== want) begin
                  if (errors < 10) begin
                     $display("%0t: mismatch kind exp %0b got %0b, pressed exp %0b got %0b",
                              $realtime, want.kind, got.kind, want.pressed, got.pressed);
                     $display("   peak exp %0d got %0d, base exp %0d got %0d, err exp %0b got %0b",
                              want.peak, got.peak, want.base, got.base, want.cal_err,
                              got.cal_err);
                  end
                  errors++;
               end
            end
         end
         if (csr_valid && csr_ready) cont = csr_data;
         if (req_tvalid && req_tready) predict_item(req_tuser, req_tdata);
         pending = verdicts_due.size();
      end
   end

endmodule

/* sim/tb_capacitive_touch_key_detector_top.sv */
module tb_capacitive_touch_key_detector_top;

   localparam int SETTLE_CYCLES = 80;
   localparam int SEGMENT_ITEMS = 154;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic                            req_tuser = ctkd_pkg::OP_CAL;
   logic [ctkd_pkg::SAMPLE_W-1:0]   req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic                            rsp_tuser;
   logic [ctkd_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic                            csr_data = 1'b0;

   int          errors;
   int          pending;
   int          req_idle_pct = 27;
   int          rsp_idle_pct = 48;
   int          sent = 0;
   logic        mode = 1'b0;
   int unsigned level = 1000;

   capacitive_touch_key_detector_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   touch_key_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .errors     (errors),
      .pending    (pending)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);

   function automatic logic [15:0] clip16(input int unsigned x);
      return (x > 65535) ? 16'hFFFF : x[15:0];
   endfunction

   function automatic logic [15:0] near(input int unsigned center, input int unsigned spread);
      int unsigned lo;
      lo = (center > spread) ? center - spread : 0;
      return clip16($urandom_range(lo, center + spread));
   endfunction

   function automatic logic [15:0] touch_value(input logic touched);
      int unsigned r;
      r = $urandom_range(19);
      if (r == 0) return 16'($urandom_range(65535));
      if (r == 1) return clip16(level * 10 - 1 + $urandom_range(2));
      if (r == 2) return clip16(level * 4 / 3 + $urandom_range(2));
      if (r == 3) return clip16(level * 5 / 4 + $urandom_range(1));
      if (touched && r > 6) return near(level * 3 / 2, level / 4 + 1);
      return near(level, level / 8 + 1);
   endfunction

   task automatic send_sample(input logic op, input logic [15:0] v);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= v;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   // wait until every expected result is in and the block has gone quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      csr_valid <= 1'b1;
      csr_data <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      mode = m;
   endtask

   task automatic scan_group();
      int n;
      int i;
      logic touched;
      n = mode ? 6 : 3;
      touched = ($urandom_range(9) < 4);
      for (i = 0; i < n; i++) send_sample(ctkd_pkg::OP_SCAN, touch_value(touched));
   endtask

   task automatic calibration_round();
      int unsigned r;
      logic flat;
      int i;
      r = $urandom_range(9);
      if (r < 2) level = $urandom_range(200);
      else if (r < 7) level = $urandom_range(300, 6000);
      else if (r == 7) level = $urandom_range(6000, 30000);
      else level = $urandom_range(30000, 65535);
      // flat rounds make the baseline equal to level, so thresholds hit exactly
      flat = ($urandom_range(9) < 3);
      for (i = 0; i < 10; i++) begin
         if ($urandom_range(9) == 0)
            send_sample(ctkd_pkg::OP_SCAN, touch_value(1'($urandom_range(1))));
         if (flat) send_sample(ctkd_pkg::OP_CAL, level[15:0]);
         else if ($urandom_range(4) == 0)
            send_sample(ctkd_pkg::OP_CAL, 16'($urandom_range(65535)));
         else send_sample(ctkd_pkg::OP_CAL, near(level, level / 16 + 1));
      end
   endtask

   initial begin
      #3_200_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int p;
      int m;
      int target;
      int unsigned r;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_mode(1'b0);
      // zero baseline, one sample over: peak 0
      send_sample(ctkd_pkg::OP_SCAN, 16'd0);
      send_sample(ctkd_pkg::OP_SCAN, 16'hFFFF);
      send_sample(ctkd_pkg::OP_SCAN, 16'd0);
      // calibration to 1000 with scans interleaved
      send_sample(ctkd_pkg::OP_CAL, 16'd0);
      send_sample(ctkd_pkg::OP_CAL, 16'hFFFF);
      send_sample(ctkd_pkg::OP_CAL, 16'hFFFF);
      send_sample(ctkd_pkg::OP_CAL, 16'd0);
      send_sample(ctkd_pkg::OP_CAL, 16'd1000);
      send_sample(ctkd_pkg::OP_CAL, 16'd1000);
      send_sample(ctkd_pkg::OP_SCAN, 16'd1300);
      send_sample(ctkd_pkg::OP_SCAN, 16'd1400);
      send_sample(ctkd_pkg::OP_CAL, 16'd1000);
      send_sample(ctkd_pkg::OP_CAL, 16'd1000);
      send_sample(ctkd_pkg::OP_CAL, 16'd1000);
      send_sample(ctkd_pkg::OP_CAL, 16'd1000);
      // press, then a press hidden by lockout
      send_sample(ctkd_pkg::OP_SCAN, 16'd1500);
      send_sample(ctkd_pkg::OP_SCAN, 16'd1500);
      send_sample(ctkd_pkg::OP_SCAN, 16'd1500);
      send_sample(ctkd_pkg::OP_SCAN, 16'd1500);
      // mode switch inside a group; a sample at the upper bound
      send_sample(ctkd_pkg::OP_SCAN, 16'd1400);
      send_sample(ctkd_pkg::OP_SCAN, 16'd1400);
      settle();
      write_mode(1'b1);
      send_sample(ctkd_pkg::OP_SCAN, 16'd10000);
      send_sample(ctkd_pkg::OP_SCAN, 16'd1400);
      send_sample(ctkd_pkg::OP_SCAN, 16'd1400);
      send_sample(ctkd_pkg::OP_SCAN, 16'd1400);

      for (p = 0; p < 3; p++) begin
         if (p == 1) begin
            req_idle_pct = 48;
            rsp_idle_pct = 27;
         end else if (p == 2) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         for (m = 0; m < 2; m++) begin
            settle();
            write_mode(((p + m) % 2) == 1);
            target = sent + SEGMENT_ITEMS;
            while (sent < target) begin
               r = $urandom_range(99);
               if (r < 12) calibration_round();
               else if (r < 92) scan_group();
               else send_sample(1'($urandom_range(1)), 16'($urandom_range(65535)));
            end
         end
      end

      settle();
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/ctkd_pkg.sv
hdl/ctkd_div.sv
hdl/ctkd_ctrl.sv
hdl/ctkd_dp.sv
hdl/capacitive_touch_key_detector_top.sv
sim/touch_key_checker.sv
sim/tb_capacitive_touch_key_detector_top.sv
